/* rtl/core/dsf_pkg.sv */
// ============================================================================
// dsf_pkg - shared types and constants of the SI text filter
// Result record and per-byte result bundle, control byte codes, phase codes.
// ============================================================================
package dsf_pkg;

    // One result word as it leaves the block (lengths already cut to 12 bits)
    typedef struct packed {
        logic [7:0]  data;
        logic        wr_main;
        logic        wr_short;
        logic        str_end;
        logic [11:0] main_len;
        logic [11:0] short_len;
    } rec_t;

    // All results caused by one input byte, compacted from slot 0 up
    typedef struct packed {
        rec_t [3:0]  rec;
        logic [1:0]  last_idx;
        logic [1:0]  kind;
        logic [4:0]  index;
        logic        single;
    } bundle_t;

    typedef enum logic [1:0] {
        PH_FIRST,
        PH_ONE_HELD,
        PH_TWO_HELD,
        PH_BODY
    } phase_t;

    localparam logic [1:0] KIND_DEFAULT = 2'd0;
    localparam logic [1:0] KIND_ONE     = 2'd1;
    localparam logic [1:0] KIND_THREE   = 2'd2;

    localparam logic REG_MAIN_CAP  = 1'b0;
    localparam logic REG_SHORT_CAP = 1'b1;

    localparam int MAIN_CAP_RESET  = 256;
    localparam int SHORT_CAP_RESET = 64;
    localparam int QUEUE_DEPTH     = 4;

    localparam logic [7:0] BYTE_NUL        = 8'h00;
    localparam logic [7:0] BYTE_SEL1_FIRST = 8'h01;
    localparam logic [7:0] BYTE_SEL1_SB    = 8'h0B;
    localparam logic [7:0] BYTE_LF         = 8'h0A;
    localparam logic [7:0] BYTE_IDX_HOLE   = 8'h0C;
    localparam logic [7:0] BYTE_IDX_MAX    = 8'h0F;
    localparam logic [7:0] BYTE_ESC3       = 8'h10;
    localparam logic [7:0] BYTE_SEL2_FIRST = 8'h11;
    localparam logic [7:0] BYTE_SEL2_LAST  = 8'h15;
    localparam logic [7:0] BYTE_SPACE      = 8'h20;
    localparam logic [7:0] BYTE_TILDE      = 8'h7E;
    localparam logic [7:0] BYTE_SHORT_ON   = 8'h86;
    localparam logic [7:0] BYTE_SHORT_OFF  = 8'h87;
    localparam logic [7:0] BYTE_CR_LF      = 8'h8A;
    localparam logic [7:0] BYTE_HI_TEXT    = 8'hA0;

endpackage

/* rtl/core/dsf_front.sv */
// ============================================================================
// dsf_front - byte classifier
// Tracks selector prefix and string state, applies up to three text steps
// per byte and pushes the compacted result bundle into the queue.
// ============================================================================
module dsf_front #(
    parameter int MAX_BUFFER = 4096
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [12:0]       cfg_wdata,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        in_byte,
    input  logic              in_last,
    output logic              push,
    output dsf_pkg::bundle_t  push_data,
    input  logic              q_full
);

    localparam int CNT_W = ($clog2(MAX_BUFFER) > 12) ? $clog2(MAX_BUFFER) : 12;
    localparam int CAP_W = ($clog2(MAX_BUFFER) + 1 > 13) ? $clog2(MAX_BUFFER) + 1 : 13;
    localparam logic [CAP_W-1:0] MAX_CAP = CAP_W'(MAX_BUFFER);
    localparam logic [CAP_W-1:0] MAIN_LIM_RST = CAP_W'(
        ((dsf_pkg::MAIN_CAP_RESET > MAX_BUFFER) ? MAX_BUFFER : dsf_pkg::MAIN_CAP_RESET) - 1);
    localparam logic [CAP_W-1:0] SHORT_LIM_RST = CAP_W'(
        ((dsf_pkg::SHORT_CAP_RESET > MAX_BUFFER) ? MAX_BUFFER : dsf_pkg::SHORT_CAP_RESET) - 1);

    typedef struct packed {
        logic             stop;
        logic [CNT_W-1:0] mcnt;
        logic [CNT_W-1:0] scnt;
        logic [7:0]       nest;
    } tstate_t;

    typedef struct packed {
        tstate_t         st;
        logic            emit;
        dsf_pkg::rec_t   rec;
    } tstep_t;

    // usable length = clamped capacity less the terminator
    function automatic logic [CAP_W-1:0] cap_limit(input logic [12:0] v);
        logic [CAP_W-1:0] ext;
        ext = CAP_W'(v);
        if (v == 13'd0) begin
            return '0;
        end else if (ext > MAX_CAP) begin
            return MAX_CAP - CAP_W'(1);
        end else begin
            return ext - CAP_W'(1);
        end
    endfunction

    function automatic logic is_text(input logic [7:0] b);
        return (b >= dsf_pkg::BYTE_SPACE && b <= dsf_pkg::BYTE_TILDE) ||
               b == dsf_pkg::BYTE_LF || b >= dsf_pkg::BYTE_HI_TEXT;
    endfunction

    function automatic logic is_sel1(input logic [7:0] b);
        return (b >= dsf_pkg::BYTE_SEL1_FIRST && b <= dsf_pkg::BYTE_SEL1_SB) ||
               (b >= dsf_pkg::BYTE_SEL2_FIRST && b <= dsf_pkg::BYTE_SEL2_LAST);
    endfunction

    function automatic tstep_t text_step(input tstate_t st, input logic [7:0] b,
                                         input logic [CAP_W-1:0] mlim,
                                         input logic [CAP_W-1:0] slim);
        tstep_t r;
        logic   ws;
        r      = '0;
        r.st   = st;
        ws     = (st.nest != 8'd0);
        if (!st.stop) begin
            if (CAP_W'(st.mcnt) >= mlim || CAP_W'(st.scnt) >= slim) begin
                r.st.stop = 1'b1;
            end else if (is_text(b)) begin
                r.st.mcnt       = st.mcnt + CNT_W'(1);
                if (ws) begin
                    r.st.scnt = st.scnt + CNT_W'(1);
                end
                r.emit          = 1'b1;
                r.rec.data      = b;
                r.rec.wr_main   = 1'b1;
                r.rec.wr_short  = ws;
            end else if (b == dsf_pkg::BYTE_CR_LF) begin
                r.st.mcnt       = st.mcnt + CNT_W'(1);
                r.emit          = 1'b1;
                r.rec.data      = dsf_pkg::BYTE_LF;
                r.rec.wr_main   = 1'b1;
            end else if (b == dsf_pkg::BYTE_SHORT_ON) begin
                r.st.nest = st.nest + 8'd1;
            end else if (b == dsf_pkg::BYTE_SHORT_OFF) begin
                r.st.nest = st.nest - 8'd1;
            end else if (b == dsf_pkg::BYTE_NUL) begin
                r.st.stop = 1'b1;
            end
            r.rec.main_len  = r.st.mcnt[11:0];
            r.rec.short_len = r.st.scnt[11:0];
        end
        return r;
    endfunction

    logic [CAP_W-1:0] main_lim_reg, short_lim_reg;

    dsf_pkg::phase_t  phase_reg, phase_next;
    logic [7:0]       held0_reg, held0_next;
    logic [7:0]       held1_reg, held1_next;
    logic [1:0]       kind_reg, kind_next;
    logic [4:0]       index_reg, index_next;
    logic             single_reg, single_next;
    tstate_t          st_reg, st_next;

    logic             accept;
    logic [2:0]       en;
    logic [7:0]       x0, x1, x2;
    tstep_t           step0, step1, step2;
    tstate_t          s1, s2;
    dsf_pkg::rec_t    cand [4];
    logic [3:0]       cand_v;
    logic [2:0]       n;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_lim_reg  <= MAIN_LIM_RST;
            short_lim_reg <= SHORT_LIM_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                dsf_pkg::REG_MAIN_CAP:  main_lim_reg  <= cap_limit(cfg_wdata);
                dsf_pkg::REG_SHORT_CAP: short_lim_reg <= cap_limit(cfg_wdata);
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (accept && in_last)) begin
            phase_reg  <= dsf_pkg::PH_FIRST;
            held0_reg  <= '0;
            held1_reg  <= '0;
            kind_reg   <= dsf_pkg::KIND_DEFAULT;
            index_reg  <= '0;
            single_reg <= 1'b0;
            st_reg     <= '0;
        end else if (accept) begin
            phase_reg  <= phase_next;
            held0_reg  <= held0_next;
            held1_reg  <= held1_next;
            kind_reg   <= kind_next;
            index_reg  <= index_next;
            single_reg <= single_next;
            st_reg     <= st_next;
        end
    end

    always_comb begin
        phase_next  = phase_reg;
        held0_next  = held0_reg;
        held1_next  = held1_reg;
        kind_next   = kind_reg;
        index_next  = index_reg;
        single_next = single_reg;
        en          = 3'b000;
        x0          = in_byte;
        x1          = in_byte;
        x2          = in_byte;

        unique case (phase_reg)
            dsf_pkg::PH_FIRST: begin
                if (in_byte == dsf_pkg::BYTE_ESC3) begin
                    if (in_last) begin
                        en[0]      = 1'b1;
                        phase_next = dsf_pkg::PH_BODY;
                    end else begin
                        held0_next = in_byte;
                        phase_next = dsf_pkg::PH_ONE_HELD;
                    end
                end else if (is_sel1(in_byte)) begin
                    kind_next   = dsf_pkg::KIND_ONE;
                    index_next  = in_byte[4:0];
                    single_next = (in_byte <= dsf_pkg::BYTE_SEL1_SB);
                    phase_next  = dsf_pkg::PH_BODY;
                end else begin
                    en[0]      = 1'b1;
                    phase_next = dsf_pkg::PH_BODY;
                end
            end
            dsf_pkg::PH_ONE_HELD: begin
                if (in_last) begin
                    en[1:0]    = 2'b11;
                    x0         = held0_reg;
                    phase_next = dsf_pkg::PH_BODY;
                end else begin
                    held1_next = in_byte;
                    phase_next = dsf_pkg::PH_TWO_HELD;
                end
            end
            dsf_pkg::PH_TWO_HELD: begin
                phase_next = dsf_pkg::PH_BODY;
                if (held1_reg == dsf_pkg::BYTE_NUL && in_byte != dsf_pkg::BYTE_NUL &&
                    in_byte <= dsf_pkg::BYTE_IDX_MAX && in_byte != dsf_pkg::BYTE_IDX_HOLE) begin
                    kind_next   = dsf_pkg::KIND_THREE;
                    index_next  = in_byte[4:0];
                    single_next = 1'b1;
                end else begin
                    // failed three-byte selector: replay held bytes as text
                    en = 3'b111;
                    x0 = held0_reg;
                    x1 = held1_reg;
                end
            end
            dsf_pkg::PH_BODY: begin
                en[0] = 1'b1;
            end
        endcase

        step0   = text_step(st_reg, x0, main_lim_reg, short_lim_reg);
        s1      = en[0] ? step0.st : st_reg;
        step1   = text_step(s1, x1, main_lim_reg, short_lim_reg);
        s2      = en[1] ? step1.st : s1;
        step2   = text_step(s2, x2, main_lim_reg, short_lim_reg);
        st_next = en[2] ? step2.st : s2;

        cand[0] = step0.rec;
        cand[1] = step1.rec;
        cand[2] = step2.rec;
        cand[3] = '0;
        cand[3].str_end   = 1'b1;
        cand[3].main_len  = st_next.mcnt[11:0];
        cand[3].short_len = st_next.scnt[11:0];
        cand_v  = {in_last, en[2] && step2.emit, en[1] && step1.emit, en[0] && step0.emit};

        // pack the valid results from slot 0 up
        push_data = '0;
        n         = 3'd0;
        for (int i = 0; i < 4; i++) begin
            if (cand_v[i]) begin
                push_data.rec[n[1:0]] = cand[i];
                n = n + 3'd1;
            end
        end
        push_data.last_idx = 2'(n - 3'd1);
        push_data.kind     = kind_next;
        push_data.index    = index_next;
        push_data.single   = single_next;
        push               = accept && (n != 3'd0);
    end

endmodule

/* rtl/core/dsf_queue.sv */
// ============================================================================
// dsf_queue - bundle queue between classifier and output sequencer
// Small register FIFO; push and pop may happen in the same cycle.
// ============================================================================
module dsf_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  dsf_pkg::bundle_t  push_data,
    output logic              full,
    input  logic              pop,
    output dsf_pkg::bundle_t  head,
    output logic              empty
);

    localparam int DEPTH = dsf_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);

    dsf_pkg::bundle_t  mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W:0]    count_reg, count_next;

    assign full  = (count_reg == (PTR_W+1)'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + (PTR_W+1)'(1);
        end else if (pop && !push) begin
            count_next = count_reg - (PTR_W+1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* rtl/core/dsf_back.sv */
// ============================================================================
// dsf_back - output sequencer
// Walks the results of the head bundle one word per cycle, while m_tready
// does not stall the output, into the registered master-side stream.
// ============================================================================
module dsf_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  dsf_pkg::bundle_t  head,
    input  logic              empty,
    output logic              pop,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [31:0]       m_tdata,
    output logic [15:0]       m_tuser,
    output logic              m_tlast
);

    logic           valid_reg;
    logic [1:0]     pos_reg;
    dsf_pkg::rec_t  rec_reg;
    logic [1:0]     kind_reg;
    logic [4:0]     index_reg;
    logic           single_reg;
    logic           last_reg;

    logic           load;
    logic           take;
    dsf_pkg::rec_t  cur;

    assign load = !valid_reg || m_tready;
    assign take = load && !empty;
    assign cur  = head.rec[pos_reg];
    assign pop  = take && (pos_reg == head.last_idx);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            pos_reg   <= '0;
        end else begin
            if (load) begin
                valid_reg <= !empty;
            end
            if (take) begin
                pos_reg <= pop ? 2'd0 : pos_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            rec_reg    <= cur;
            kind_reg   <= head.kind;
            index_reg  <= head.index;
            single_reg <= head.single;
            last_reg   <= (pos_reg == head.last_idx);
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {rec_reg.short_len, rec_reg.main_len, rec_reg.data};
    assign m_tuser  = {5'd0, single_reg, index_reg, kind_reg,
                       rec_reg.str_end, rec_reg.wr_short, rec_reg.wr_main};
    assign m_tlast  = last_reg;

endmodule

/* rtl/core/dvb_si_text_filter.sv */
// ============================================================================
// dvb_si_text_filter - DVB SI text string control-code filter
// Strips the character-table selector and control codes from SI strings.
// ============================================================================
// Usage:
//   Slave stream carries one string byte per word, s_tlast on its final byte.
//   Master stream carries one word per byte written to the main text and/or
//   short name, plus one closing word (string_end) per string. m_tlast marks
//   the last word caused by one input byte. Selector bytes and dropped
//   control bytes produce no word.
//   Config: cfg_we writes cfg_wdata into main (index 0) or short (index 1)
//   capacity; write only while the block is idle.
// Throughput:
//   One byte per cycle is accepted while the queue is not full; each word is
//   registered at the output. A byte yields up to 4 words (three text plus
//   closing); the 4-entry queue absorbs these until s_tready drops.
// Reset: aresetn (sync, active low) empties queue and output register and
//   returns capacities to 256 / 64 and string state to the start of a string.
// Stall: m_tready low holds the word; the queue fills, then s_tready falls.
// ============================================================================
module dvb_si_text_filter #(
    parameter int MAX_BUFFER = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,
    // config write port
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [12:0] cfg_wdata,
    // input bytes
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tlast,   // last_byte
    // results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [7:0] out_byte, [19:8] main_length,
                                   // [31:20] short_length
    output logic [15:0] m_tuser,   // [0] write_main, [1] write_short,
                                   // [2] string_end, [4:3] charset_kind,
                                   // [9:5] charset_index, [10] single_byte
    output logic        m_tlast    // run_last
);

    logic              push;
    logic              pop;
    logic              q_full;
    logic              q_empty;
    dsf_pkg::bundle_t  push_data;
    dsf_pkg::bundle_t  q_head;

    // classifier: prefix parsing, counters, capacity stop
    dsf_front #(
        .MAX_BUFFER (MAX_BUFFER)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_byte   (s_tdata),
        .in_last   (s_tlast),
        .push      (push),
        .push_data (push_data),
        .q_full    (q_full)
    );

    // decouples byte intake from word output
    dsf_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .head      (q_head),
        .empty     (q_empty)
    );

    // one result word per cycle onto the master stream while m_tready does not stall it
    dsf_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .head      (q_head),
        .empty     (q_empty),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

/* rtl/core/dsf_checker.sv */
// ============================================================================
// dsf_checker - port-level checks of the SI text filter
// Watches the top-level ports only; bound to every instance of the top.
// ============================================================================
module dsf_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [15:0] m_tuser,
    input logic        m_tlast
);

    // closing word writes nothing and ends the run of its byte
    a_end_word: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[2] |-> !m_tuser[0] && !m_tuser[1] &&
                                   m_tdata[7:0] == 8'd0 && m_tlast)
        else $error("closing word carries data or is not run end");

    // short-name bytes are always main-text bytes too
    a_short_in_main: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tuser[0])
        else $error("short-name write without main write");

    // default table reports no index and multi-byte
    a_default_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[4:3] == 2'd0 |-> m_tuser[9:5] == 5'd0 && !m_tuser[10])
        else $error("default table with index or single-byte flag");

    // stalled output word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) &&
                                  $stable(m_tuser) && $stable(m_tlast))
        else $error("output word changed while stalled");

endmodule

bind dvb_si_text_filter dsf_checker u_dsf_checker (.*);
